### hdl/age_sort_pkg.sv
package age_sort_pkg;

    // field widths of the channels
    localparam int unsigned IssueW = 32;
    localparam int unsigned SlotW  = 5;
    localparam int unsigned CountW = 5;

    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic load;   // slot transaction accepted
        logic close;  // accepted slot closes the set
        logic pop;    // result transaction accepted
    } cmd_t;

    typedef struct packed {
        logic final_entry;  // head entry is the last one to go out
    } status_t;

endpackage

### hdl/age_order_entry_sorter_unit.sv
// channel  | direction | fields
// s_       | in        | busy_req, issue_number, last_slot
// m_       | out       | slot_index, ordered_issue_number, busy_count, empty_res, last_result
//
// slots are taken one per cycle and placed into a sorted insertion chain on arrival
// the slot transaction with last_slot set closes the set; results then leave one per
// cycle from the head of the chain, max(busy slots, 1) results in all, slots wait meanwhile
// a stall on m_ready holds the head entry; no slot is taken until the last result goes
// aresetn (synchronous) empties the chain and the slot counter
module age_order_entry_sorter_unit #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_busy_req,
    input  logic [31:0] s_issue_number,
    input  logic        s_last_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_slot_index,
    output logic [31:0] m_ordered_issue_number,
    output logic [4:0]  m_busy_count,
    output logic        m_empty_res,
    output logic        m_last_result
);

    age_sort_pkg::cmd_t    cmd;
    age_sort_pkg::status_t status;

    age_sort_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_slot (s_last_slot),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    age_sort_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .status                 (status),
        .s_busy_req             (s_busy_req),
        .s_issue_number         (s_issue_number),
        .m_slot_index           (m_slot_index),
        .m_ordered_issue_number (m_ordered_issue_number),
        .m_busy_count           (m_busy_count),
        .m_empty_res            (m_empty_res),
        .m_last_result          (m_last_result)
    );

endmodule

### hdl/age_sort_ctrl.sv
module age_sort_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_last_slot,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  age_sort_pkg::status_t status,
    output age_sort_pkg::cmd_t    cmd
);

    age_sort_pkg::state_t state_reg;
    age_sort_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= age_sort_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            age_sort_pkg::ST_LOAD: begin
                if (s_valid && s_last_slot) begin
                    state_next = age_sort_pkg::ST_EMIT;
                end
            end
            age_sort_pkg::ST_EMIT: begin
                if (m_ready && status.final_entry) begin
                    state_next = age_sort_pkg::ST_LOAD;
                end
            end
            default: state_next = age_sort_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cmd.load  = 1'b0;
        cmd.close = 1'b0;
        cmd.pop   = 1'b0;
        unique case (state_reg)
            age_sort_pkg::ST_LOAD: begin
                s_ready   = 1'b1;
                cmd.load  = s_valid;
                cmd.close = s_valid && s_last_slot;
            end
            age_sort_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                cmd.pop = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/age_sort_dp.sv
module age_sort_dp #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  age_sort_pkg::cmd_t                     cmd,
    output age_sort_pkg::status_t                  status,
    input  logic                                   s_busy_req,
    input  logic [age_sort_pkg::IssueW-1:0]        s_issue_number,
    output logic [age_sort_pkg::SlotW-1:0]         m_slot_index,
    output logic [age_sort_pkg::IssueW-1:0]        m_ordered_issue_number,
    output logic [age_sort_pkg::CountW-1:0]        m_busy_count,
    output logic                                   m_empty_res,
    output logic                                   m_last_result
);

    localparam int unsigned KeyW  = (KEY_BITS > age_sort_pkg::IssueW) ?
                                    age_sort_pkg::IssueW : KEY_BITS;
    localparam int unsigned SlotW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CntW  = $clog2(ENTRIES + 1);

    logic [KeyW-1:0]  key_reg   [ENTRIES];
    logic [KeyW-1:0]  key_next  [ENTRIES];
    logic [SlotW-1:0] slot_reg  [ENTRIES];
    logic [SlotW-1:0] slot_next [ENTRIES];
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic [CntW-1:0]  total_reg;
    logic [CntW-1:0]  total_next;
    logic [CntW-1:0]  slot_cnt_reg;
    logic [CntW-1:0]  slot_cnt_next;

    logic [KeyW-1:0]  new_key;
    logic [SlotW-1:0] new_slot;
    logic             insert;
    logic [CntW-1:0]  count_ins;
    logic [ENTRIES-1:0] gt;

    assign new_key  = s_issue_number[KeyW-1:0];
    assign new_slot = slot_cnt_reg[SlotW-1:0];
    // slot counter never passes ENTRIES, and while loading count never passes the slot counter
    assign insert   = cmd.load && s_busy_req && (slot_cnt_reg < CntW'(ENTRIES));
    assign count_ins = count_reg + CntW'(insert);

    // entries strictly larger than the new key form a suffix of the valid part
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            gt[i] = (CntW'(i) < count_reg) && (key_reg[i] > new_key);
        end
    end

    always_comb begin
        logic gt_prev;
        for (int i = 0; i < ENTRIES; i++) begin
            gt_prev      = (i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1];
            key_next[i]  = key_reg[i];
            slot_next[i] = slot_reg[i];
            if (insert) begin
                if (gt_prev) begin
                    key_next[i]  = key_reg[(i == 0) ? 0 : i - 1];
                    slot_next[i] = slot_reg[(i == 0) ? 0 : i - 1];
                end else if (gt[i] || (count_reg == CntW'(i))) begin
                    key_next[i]  = new_key;
                    slot_next[i] = new_slot;
                end
            end else if (cmd.pop && (i < ENTRIES - 1)) begin
                key_next[i]  = key_reg[(i < ENTRIES - 1) ? i + 1 : i];
                slot_next[i] = slot_reg[(i < ENTRIES - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        count_next    = count_reg;
        total_next    = total_reg;
        slot_cnt_next = slot_cnt_reg;
        if (cmd.load) begin
            count_next = count_ins;
            if (slot_cnt_reg < CntW'(ENTRIES)) begin
                slot_cnt_next = slot_cnt_reg + CntW'(1);
            end
            if (cmd.close) begin
                total_next    = count_ins;
                slot_cnt_next = '0;
            end
        end else if (cmd.pop && (count_reg != '0)) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            total_reg    <= '0;
            slot_cnt_reg <= '0;
        end else begin
            count_reg    <= count_next;
            total_reg    <= total_next;
            slot_cnt_reg <= slot_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

    assign status.final_entry = (count_reg <= CntW'(1));

    assign m_empty_res            = (total_reg == '0);
    assign m_slot_index           = m_empty_res ? age_sort_pkg::SlotW'(ENTRIES)
                                                : age_sort_pkg::SlotW'(slot_reg[0]);
    assign m_ordered_issue_number = m_empty_res ? '0 : age_sort_pkg::IssueW'(key_reg[0]);
    assign m_busy_count           = age_sort_pkg::CountW'(total_reg);
    assign m_last_result          = (count_reg <= CntW'(1));

endmodule

### hdl/age_sort_checker.sv
module age_sort_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_slot,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_ordered_issue_number,
    input logic [4:0]  m_busy_count,
    input logic        m_empty_res,
    input logic        m_last_result
);

    // slots and results never move in the same cycle
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("slot and result channels open together");

    // closing slot starts the result run
    a_close_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_slot |=> m_valid)
        else $error("no result after closing slot");

    // run continues until the final result
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> m_valid)
        else $error("result run stopped early");

    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last_result && (m_busy_count == 5'd0))
        else $error("empty result malformed");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ordered_issue_number))
        else $error("stalled result changed");

endmodule

bind age_order_entry_sorter_unit age_sort_checker u_age_sort_checker (
    .aclk                   (aclk),
    .aresetn                (aresetn),
    .s_valid                (s_valid),
    .s_ready                (s_ready),
    .s_last_slot            (s_last_slot),
    .m_valid                (m_valid),
    .m_ready                (m_ready),
    .m_ordered_issue_number (m_ordered_issue_number),
    .m_busy_count           (m_busy_count),
    .m_empty_res            (m_empty_res),
    .m_last_result          (m_last_result)
);

### bench/tb_age_order_entry_sorter_unit.sv
module tb_age_order_entry_sorter_unit;

    localparam int unsigned NUM_SLOTS = 16;
    localparam int unsigned RANDOM_SLOTS = 230;

    typedef struct {
        logic                            busy;
        logic [age_sort_pkg::IssueW-1:0] issue;
        logic                            last;
    } slot_txn_t;

    typedef struct {
        logic [age_sort_pkg::SlotW-1:0]  slot;
        logic [age_sort_pkg::IssueW-1:0] issue;
        logic [age_sort_pkg::CountW-1:0] count;
        logic                            empty;
        logic                            last;
    } ordered_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_busy_req = 1'b0;
    logic [31:0] s_issue_number = '0;
    logic        s_last_slot = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_slot_index;
    logic [31:0] m_ordered_issue_number;
    logic [4:0]  m_busy_count;
    logic        m_empty_res;
    logic        m_last_result;

    age_order_entry_sorter_unit #(
        .ENTRIES (NUM_SLOTS),
        .KEY_BITS(age_sort_pkg::IssueW)
    ) dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_busy_req            (s_busy_req),
        .s_issue_number        (s_issue_number),
        .s_last_slot           (s_last_slot),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_slot_index          (m_slot_index),
        .m_ordered_issue_number(m_ordered_issue_number),
        .m_busy_count          (m_busy_count),
        .m_empty_res           (m_empty_res),
        .m_last_result         (m_last_result)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    slot_txn_t      slot_q[$];
    ordered_entry_t age_order_q[$];

    // shadow of the sorted chain
    logic [age_sort_pkg::IssueW-1:0] chain_key[NUM_SLOTS];
    logic [3:0]                      chain_slot[NUM_SLOTS];
    int unsigned       chain_fill = 0;
    int unsigned       slot_pos = 0;

    int unsigned n_slots_total = 0;
    int unsigned n_slots_taken = 0;
    int          n_errors = 0;

    slot_txn_t   cur_slot;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    function automatic int unsigned idle_cycles(inout bit burst);
        if ($urandom_range(0, 15) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    // insertion into the chain; a closing slot dumps the chain oldest first
    function automatic void predict_age_order(input slot_txn_t txn);
        int unsigned    pos;
        ordered_entry_t res;
        if (slot_pos < NUM_SLOTS) begin
            if (txn.busy && chain_fill < NUM_SLOTS) begin
                pos = chain_fill;
                // equal keys stay behind older slots
                while (pos > 0 && chain_key[pos-1] > txn.issue) begin
                    chain_key[pos]  = chain_key[pos-1];
                    chain_slot[pos] = chain_slot[pos-1];
                    pos--;
                end
                chain_key[pos]  = txn.issue;
                chain_slot[pos] = slot_pos[3:0];
                chain_fill++;
            end
            slot_pos++;
        end
        if (txn.last) begin
            if (chain_fill == 0) begin
                res.slot  = NUM_SLOTS[age_sort_pkg::SlotW-1:0];
                res.issue = '0;
                res.count = '0;
                res.empty = 1'b1;
                res.last  = 1'b1;
                age_order_q.push_back(res);
            end else begin
                for (int unsigned k = 0; k < chain_fill; k++) begin
                    res.slot  = {1'b0, chain_slot[k]};
                    res.issue = chain_key[k];
                    res.count = chain_fill[age_sort_pkg::CountW-1:0];
                    res.empty = 1'b0;
                    res.last  = (k + 1 == chain_fill);
                    age_order_q.push_back(res);
                end
            end
            chain_fill = 0;
            slot_pos   = 0;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            n_errors++;
        end
    endtask

    task automatic add_slot(input logic busy, input logic [age_sort_pkg::IssueW-1:0] issue,
                            input logic last);
        slot_txn_t txn;
        txn.busy  = busy;
        txn.issue = issue;
        txn.last  = last;
        slot_q.push_back(txn);
        n_slots_total++;
    endtask

    // slot driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_age_order(cur_slot);
                n_slots_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (slot_q.size() > 0) begin
                    cur_slot = slot_q.pop_front();
                    s_busy_req     <= cur_slot.busy;
                    s_issue_number <= cur_slot.issue;
                    s_last_slot    <= cur_slot.last;
                    s_valid        <= 1'b1;
                    send_gap = idle_cycles(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        ordered_entry_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (age_order_q.size() == 0) begin
                    $error("result transaction with nothing expected, slot_index 0x%0h",
                           m_slot_index);
                    n_errors++;
                end else begin
                    want = age_order_q.pop_front();
                    check_field("slot_index", 32'(want.slot), 32'(m_slot_index));
                    check_field("ordered_issue_number", want.issue, m_ordered_issue_number);
                    check_field("busy_count", 32'(want.count), 32'(m_busy_count));
                    check_field("empty_res", 32'(want.empty), 32'(m_empty_res));
                    check_field("last_result", 32'(want.last), 32'(m_last_result));
                end
                recv_stall = idle_cycles(recv_burst);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned set_len;
        int unsigned busy_mode;
        int unsigned key_mode;
        logic        busy;
        logic [31:0] key;

        // one empty slot closes an empty set
        add_slot(1'b0, 32'h0000_0000, 1'b1);
        // single busy slot with the largest key
        add_slot(1'b1, 32'hFFFF_FFFF, 1'b1);
        // ties and both key extremes
        add_slot(1'b1, 32'h0000_0005, 1'b0);
        add_slot(1'b1, 32'h0000_0005, 1'b0);
        add_slot(1'b1, 32'h0000_0000, 1'b0);
        add_slot(1'b1, 32'hFFFF_FFFF, 1'b1);
        // overfull set: descending pairs of equal keys, two extra slots, closed past the end
        for (int i = 0; i < 18; i++) begin
            add_slot(1'b1, 32'h0000_1000 - (i / 2), i == 17);
        end

        while (n_slots_total < RANDOM_SLOTS) begin
            set_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
                                                    : $urandom_range(1, 16);
            busy_mode = $urandom_range(0, 5);
            key_mode  = $urandom_range(0, 2);
            for (int unsigned i = 0; i < set_len; i++) begin
                case (busy_mode)
                    0: busy = 1'b0;
                    1, 2: busy = 1'b1;
                    default: busy = 1'($urandom_range(0, 1));
                endcase
                case (key_mode)
                    0: key = $urandom_range(0, 7);
                    1: key = $urandom;
                    default: begin
                        case ($urandom_range(0, 2))
                            0: key = 32'h0000_0000;
                            1: key = 32'hFFFF_FFFF;
                            default: key = $urandom;
                        endcase
                    end
                endcase
                add_slot(busy, key, i + 1 == set_len);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_slots_taken != n_slots_total || age_order_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        if (n_errors == 0) begin
            $display("PASS age_order_entry_sorter_unit");
        end else begin
            $display("FAIL age_order_entry_sorter_unit");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL age_order_entry_sorter_unit");
        $finish;
    end

endmodule
